// ----- rtl/edfs_pkg.sv -----
// shared types and constants for the deadline scheduler
`timescale 1ns / 1ps
package edfs_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_ENABLE = 2'd2;

    // register map, selected by address bit 2
    localparam logic REG_TICK_PERIOD = 1'b0;
    localparam logic REG_SCHED_ON    = 1'b1;

    // deadline that can never be picked, also the seed of a scan
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // slot index width on the chain, covers the largest slot count
    localparam int PICK_W = 6;

    // running best candidate handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [31:0]       best;
        logic [PICK_W-1:0] pick;
    } t_link;

    // slot programming word broadcast to the cells
    typedef struct packed {
        logic        load;
        logic        set_en;
        logic [31:0] period;
        logic [31:0] deadline;
        logic        periodic;
        logic        enable;
    } t_slot_wr;

endpackage

// ----- rtl/edfs_cell.sv -----
// one task slot: holds its state and compares against the running best
`timescale 1ns / 1ps
module edfs_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [31:0]      i_now,
    input  edfs_pkg::t_slot_wr i_wr,
    input  logic             i_wr_sel,
    input  logic             i_wb,
    input  edfs_pkg::t_link  i_link,
    output edfs_pkg::t_link  o_link
);
    import edfs_pkg::*;

    logic [31:0] r_release;
    logic [31:0] r_period;
    logic [31:0] r_deadline;
    logic        r_enabled;
    logic        r_periodic;
    t_link       r_link;
    t_link       n_link;

    logic [31:0] w_due;
    logic        w_take;

    // released, eligible and earlier than everything to the left
    assign w_due  = r_release + r_deadline;
    assign w_take = r_enabled && r_periodic && (i_now >= r_release) && (w_due < i_link.best);

    // slot state: programming and release advance after a pick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release  <= '0;
            r_period   <= '0;
            r_deadline <= '0;
            r_enabled  <= 1'b0;
            r_periodic <= 1'b0;
        end else if (i_wr_sel && i_wr.load) begin
            r_release  <= i_wr.period;
            r_period   <= i_wr.period;
            r_deadline <= i_wr.deadline;
            r_enabled  <= i_wr.enable;
            r_periodic <= i_wr.periodic;
        end else if (i_wr_sel && i_wr.set_en) begin
            r_enabled <= i_wr.enable;
        end else if (i_wb) begin
            r_release <= r_release + r_period;
        end
    end

    // this slot replaces the candidate when it is earlier
    always_comb begin
        n_link = i_link;
        if (i_link.valid && w_take) begin
            n_link.found = 1'b1;
            n_link.best  = w_due;
            n_link.pick  = PICK_W'(IDX);
        end
    end

    // hand the best candidate on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

// ----- rtl/edf_periodic_task_scheduler_top.sv -----
// a tick with the scheduler on is taken when start is high and busy low; busy then stays
//   high through the time multiply, the scan and the decision
// the result strobe is registered from the decision; a new tick is taken only after the
//   last one is done, its steps being the accepting cycle, the time multiply, the walk
//   of the candidate down the row of slot cells, one cell a cycle, and the decision and
//   write-back
// load and enable words give no result and leave busy low; results cannot be stalled
// synchronous active-low reset clears all slots, counters and registers, but the tick period resets to 100
`timescale 1ns / 1ps
module edf_periodic_task_scheduler_top #(
    parameter int SLOT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_slot_index,
    input  logic [31:0] i_period_value,
    input  logic [31:0] i_deadline_value,
    input  logic        i_is_periodic,
    input  logic        i_enable_bit,
    // result channel
    output logic        o_valid,
    output logic [2:0]  o_chosen_slot,
    output logic        o_idle_flag,
    output logic [31:0] o_idle_total,
    output logic [31:0] o_now_us,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import edfs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN
    } t_state;

    t_state      r_state;
    logic [15:0] r_tick_period;
    logic        r_sched_on;
    logic [31:0] r_tick;
    logic [31:0] r_idle;
    logic [31:0] r_now;
    logic        r_launch;

    logic        w_accept;
    logic        w_done;
    logic [47:0] w_prod;
    logic [31:0] n_idle;
    t_slot_wr    w_wr;
    t_link       w_link [SLOT_COUNT+1];
    logic [SLOT_COUNT-1:0] w_wr_sel;
    logic [SLOT_COUNT-1:0] w_wb;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SCHED_ON) ? {31'b0, r_sched_on} : {16'b0, r_tick_period};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= 16'd100;
            r_sched_on    <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_TICK_PERIOD) begin
                r_tick_period <= pwdata[15:0];
            end else begin
                r_sched_on <= pwdata[0];
            end
        end
    end

    // command word decode
    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    assign w_wr.load     = w_accept && (i_command == CMD_LOAD);
    assign w_wr.set_en   = w_accept && (i_command == CMD_ENABLE);
    assign w_wr.period   = i_period_value;
    assign w_wr.deadline = i_deadline_value;
    assign w_wr.periodic = i_is_periodic;
    assign w_wr.enable   = i_enable_bit;

    // scan seed and end of scan
    assign w_link[0] = '{valid: r_launch, found: 1'b0, best: ALL_ONES, pick: '0};
    assign w_done    = (r_state == ST_SCAN) && w_link[SLOT_COUNT].valid;
    assign w_prod    = r_tick * r_tick_period;
    assign n_idle    = w_link[SLOT_COUNT].found ? r_idle : r_idle + 32'd1;

    // row of slot cells
    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        assign w_wr_sel[k] = (PICK_W'(i_slot_index) == PICK_W'(k));
        assign w_wb[k]     = w_done && w_link[SLOT_COUNT].found
                             && (w_link[SLOT_COUNT].pick == PICK_W'(k));

        edfs_cell #(
            .IDX (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_now    (r_now),
            .i_wr     (w_wr),
            .i_wr_sel (w_wr_sel[k]),
            .i_wb     (w_wb[k]),
            .i_link   (w_link[k]),
            .o_link   (w_link[k+1])
        );
    end

    // sequencer, counters and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_tick        <= '0;
            r_idle        <= '0;
            r_now         <= '0;
            r_launch      <= 1'b0;
            o_valid       <= 1'b0;
            o_idle_flag   <= 1'b0;
            o_idle_total  <= '0;
            o_now_us      <= '0;
            o_chosen_slot <= '0;
        end else begin
            r_launch <= (r_state == ST_MUL);
            o_valid  <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_command == CMD_TICK)) begin
                        r_tick <= r_tick + 32'd1;
                        if (r_sched_on) begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_now   <= w_prod[31:0];
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (w_done) begin
                        r_idle        <= n_idle;
                        o_valid       <= 1'b1;
                        o_idle_flag   <= !w_link[SLOT_COUNT].found;
                        o_idle_total  <= n_idle;
                        o_now_us      <= r_now;
                        o_chosen_slot <= w_link[SLOT_COUNT].found
                                         ? 3'(w_link[SLOT_COUNT].pick)
                                         : 3'(SLOT_COUNT - 1);
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/edfs_checker.sv -----
// port-level checks on the scheduler and their bind to the top level
`timescale 1ns / 1ps
module edfs_checker #(
    parameter int SLOT_COUNT = 8
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_valid,
    input logic [2:0] o_chosen_slot,
    input logic       o_idle_flag
);

    // reset always leaves the block free to take a word
    a_reset_free: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy after reset");

    // a result only ends a run of work
    a_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without preceding work");

    // one tick gives a single-cycle strobe
    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // idle reports the last slot
    a_idle_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_idle_flag) |-> (o_chosen_slot == 3'(SLOT_COUNT - 1)))
        else $error("idle result does not report the last slot");

endmodule

bind edf_periodic_task_scheduler_top edfs_checker #(
    .SLOT_COUNT (SLOT_COUNT)
) u_edfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_chosen_slot (o_chosen_slot),
    .o_idle_flag   (o_idle_flag)
);

// ----- dv/edf_periodic_task_scheduler_top_tb.sv -----
// self-checking testbench for the edf scheduler top: directed cases, then random command words
`timescale 1ns / 1ps
module edf_periodic_task_scheduler_top_tb;
    import edfs_pkg::*;

    localparam int SLOTS       = 8;
    localparam int LATENCY     = SLOTS + 2;
    localparam int STALL_LIMIT = 4000;

    // command 3 has no meaning, the block drops it
    localparam logic [1:0] CMD_UNUSED       = 2'd3;
    localparam logic [2:0] ADDR_TICK_PERIOD = {REG_TICK_PERIOD, 2'b00};
    localparam logic [2:0] ADDR_SCHED_ON    = {REG_SCHED_ON, 2'b00};
    localparam logic [2:0] IDLE_SLOT        = 3'(SLOTS - 1);

    // one scheduling decision as seen on the result ports
    typedef struct packed {
        logic [2:0]  slot;
        logic        idle;
        logic [31:0] idle_total;
        logic [31:0] now;
    } t_decision;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic [1:0]  i_command        = CMD_TICK;
    logic [2:0]  i_slot_index     = '0;
    logic [31:0] i_period_value   = '0;
    logic [31:0] i_deadline_value = '0;
    logic        i_is_periodic    = 1'b0;
    logic        i_enable_bit     = 1'b0;
    logic        o_valid;
    logic [2:0]  o_chosen_slot;
    logic        o_idle_flag;
    logic [31:0] o_idle_total;
    logic [31:0] o_now_us;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [2:0]  paddr            = '0;
    logic [31:0] pwdata           = '0;
    logic [31:0] prdata;
    logic        pready;

    // scheduler mirror: registers, counters and slot table
    logic [15:0] cfg_tick_us;
    logic        cfg_on;
    logic [31:0] ticks_seen;
    logic [31:0] idle_seen;
    logic [31:0] rel_at      [SLOTS];
    logic [31:0] period_of   [SLOTS];
    logic [31:0] deadline_of [SLOTS];
    logic        slot_en     [SLOTS];
    logic        slot_per    [SLOTS];

    t_decision due_decisions[$];
    int        miscompares  = 0;
    int        stall_cycles = 0;
    int        idle_pct     = 36;

    edf_periodic_task_scheduler_top #(
        .SLOT_COUNT(SLOTS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_slot_index    (i_slot_index),
        .i_period_value  (i_period_value),
        .i_deadline_value(i_deadline_value),
        .i_is_periodic   (i_is_periodic),
        .i_enable_bit    (i_enable_bit),
        .o_valid         (o_valid),
        .o_chosen_slot   (o_chosen_slot),
        .o_idle_flag     (o_idle_flag),
        .o_idle_total    (o_idle_total),
        .o_now_us        (o_now_us),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void reset_mirror();
        cfg_tick_us = 16'd100;
        cfg_on      = 1'b0;
        ticks_seen  = '0;
        idle_seen   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            rel_at[i]      = '0;
            period_of[i]   = '0;
            deadline_of[i] = '0;
            slot_en[i]     = 1'b0;
            slot_per[i]    = 1'b0;
        end
    endfunction

    // apply one accepted word to the mirror, queue the decision a tick makes
    function automatic void edf_decide(input logic [1:0] cmd, input logic [2:0] slot,
                                       input logic [31:0] period, input logic [31:0] deadline,
                                       input logic periodic, input logic en);
        logic [31:0] now;
        logic [31:0] best;
        logic [31:0] due;
        int          pick;
        t_decision   d;
        case (cmd)
            CMD_LOAD: begin
                if (int'(slot) < SLOTS) begin
                    period_of[slot]   = period;
                    deadline_of[slot] = deadline;
                    slot_per[slot]    = periodic;
                    slot_en[slot]     = en;
                    rel_at[slot]      = period;
                end
            end
            CMD_ENABLE: begin
                if (int'(slot) < SLOTS) slot_en[slot] = en;
            end
            CMD_TICK: begin
                ticks_seen = ticks_seen + 1;
                if (cfg_on) begin
                    now  = ticks_seen * 32'(cfg_tick_us);
                    best = ALL_ONES;
                    pick = SLOTS;
                    // earliest absolute deadline among released slots, lowest index on ties
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_en[i] && slot_per[i] && now >= rel_at[i]) begin
                            due = rel_at[i] + deadline_of[i];
                            if (due < best) begin
                                best = due;
                                pick = i;
                            end
                        end
                    end
                    if (pick == SLOTS) begin
                        idle_seen = idle_seen + 1;
                        d.slot    = IDLE_SLOT;
                        d.idle    = 1'b1;
                    end else begin
                        rel_at[pick] = rel_at[pick] + period_of[pick];
                        d.slot       = 3'(pick);
                        d.idle       = 1'b0;
                    end
                    d.idle_total = idle_seen;
                    d.now        = now;
                    due_decisions.push_back(d);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void note_miscompare(input string what);
        miscompares++;
        if (miscompares <= 10) $display("mismatch at %0t: %s", $time, what);
    endfunction

    // compare every result word with the oldest pending decision
    always @(posedge i_clk) begin : result_check
        t_decision want;
        if (i_rst_n && o_valid) begin
            if (due_decisions.size() == 0) begin
                note_miscompare($sformatf("unexpected result slot %0d idle %0d total %0d now %0d",
                                          o_chosen_slot, o_idle_flag, o_idle_total, o_now_us));
            end else begin
                want = due_decisions.pop_front();
                if (o_chosen_slot !== want.slot || o_idle_flag !== want.idle ||
                    o_idle_total !== want.idle_total || o_now_us !== want.now) begin
                    note_miscompare($sformatf(
                        "exp slot %0d idle %0d total %0d now %0d, got %0d %0d %0d %0d",
                        want.slot, want.idle, want.idle_total, want.now,
                        o_chosen_slot, o_idle_flag, o_idle_total, o_now_us));
                end
            end
        end
    end

    // cycles without any accepted word, result or register access
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((start && !busy) || o_valid || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("** edf_periodic_task_scheduler_top: FAILED **");
        $finish;
    end

    // drive one command word with a random lead-in gap, return at its accepting edge
    task automatic send_word(input logic [1:0] cmd, input logic [2:0] slot,
                             input logic [31:0] period, input logic [31:0] deadline,
                             input logic periodic, input logic en);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start            <= 1'b1;
        i_command        <= cmd;
        i_slot_index     <= slot;
        i_period_value   <= period;
        i_deadline_value <= deadline;
        i_is_periodic    <= periodic;
        i_enable_bit     <= en;
        do @(posedge i_clk); while (busy);
        edf_decide(cmd, slot, period, deadline, periodic, en);
    endtask

    // drain all pending decisions, then let a trailing load or enable finish
    task automatic settle();
        start <= 1'b0;
        while (due_decisions.size() != 0 || busy) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        start   <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_TICK_PERIOD) cfg_tick_us = value[15:0];
        else cfg_on = value[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // ticks while off after reset, then an idle decision with an empty table
    task automatic test_idle_after_reset();
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        send_word(CMD_TICK, 3'd7, '1, '1, 1'b1, 1'b1);
        settle();
        write_reg(ADDR_SCHED_ON, 32'd1);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        settle();
    endtask

    // ties, all-ones deadline, idle last slot, non-periodic slot, dropped command
    task automatic test_edf_selection();
        send_word(CMD_LOAD, 3'd0, 32'd150, 32'd1000, 1'b1, 1'b1);
        send_word(CMD_LOAD, 3'd3, 32'd150, 32'd1000, 1'b1, 1'b1);
        send_word(CMD_LOAD, 3'd7, ALL_ONES, 32'd0, 1'b1, 1'b1);
        send_word(CMD_LOAD, 3'd5, 32'd100, ALL_ONES - 32'd100, 1'b1, 1'b1);
        send_word(CMD_LOAD, 3'd2, 32'd0, 32'd0, 1'b0, 1'b1);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        send_word(CMD_ENABLE, 3'd3, '0, '0, 1'b1, 1'b0);
        send_word(CMD_UNUSED, 3'd7, '1, '1, 1'b1, 1'b1);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        send_word(CMD_ENABLE, 3'd0, '1, '1, 1'b0, 1'b0);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        send_word(CMD_LOAD, 3'd1, 32'd0, 32'd0, 1'b1, 1'b1);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        send_word(CMD_ENABLE, 3'd1, '0, '0, 1'b0, 1'b0);
        settle();
    endtask

    // ticks while off still advance the count
    task automatic test_scheduler_off();
        write_reg(ADDR_SCHED_ON, 32'd0);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        settle();
        write_reg(ADDR_SCHED_ON, 32'd1);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        settle();
    endtask

    // zero tick period pins time at zero, then the largest period
    task automatic test_tick_period_extremes();
        write_reg(ADDR_TICK_PERIOD, 32'd0);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        settle();
        write_reg(ADDR_TICK_PERIOD, 32'hFFFF);
        send_word(CMD_TICK, 3'd0, '0, '0, 1'b0, 1'b0);
        settle();
    endtask

    // random words, loads mostly shaped so slots get released and compete
    task automatic test_random_traffic(input int words, input int gap_pct,
                                       input logic [15:0] tick_us);
        int          sent;
        int unsigned r;
        int unsigned span;
        logic [1:0]  cmd;
        logic [2:0]  slot;
        logic [31:0] period;
        logic [31:0] deadline;
        logic [31:0] now_next;
        logic        periodic;
        logic        en;
        sent     = 0;
        span     = (tick_us == 0) ? 100 : int'(tick_us);
        idle_pct = gap_pct;
        settle();
        write_reg(ADDR_TICK_PERIOD, 32'(tick_us));
        write_reg(ADDR_SCHED_ON, 32'd1);
        while (sent < words) begin
            r        = $urandom_range(99);
            cmd      = (r < 50) ? CMD_TICK : (r < 75) ? CMD_LOAD :
                       (r < 93) ? CMD_ENABLE : CMD_UNUSED;
            slot     = 3'($urandom_range(SLOTS - 1));
            period   = $urandom;
            deadline = $urandom;
            periodic = 1'($urandom_range(1));
            en       = 1'($urandom_range(1));
            if (cmd == CMD_LOAD) begin
                now_next = (ticks_seen + 1) * 32'(cfg_tick_us);
                r = $urandom_range(99);
                if (r < 50) period = $urandom_range(4 * span, 1);
                else if (r < 75) period = now_next + $urandom_range(8 * span);
                else if (r < 80) period = '0;
                else if (r < 88) period = ALL_ONES;
                r = $urandom_range(99);
                if (r < 60) deadline = $urandom_range(16 * span);
                else if (r < 75) deadline = ALL_ONES - period;
                else if (r < 85) deadline = '0;
                periodic = ($urandom_range(99) < 85);
                en       = ($urandom_range(99) < 85);
            end else if (cmd == CMD_ENABLE) begin
                en = ($urandom_range(99) < 70);
            end
            send_word(cmd, slot, period, deadline, periodic, en);
            sent++;
        end
        settle();
    endtask

    initial begin
        reset_mirror();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_after_reset();
        test_edf_selection();
        test_scheduler_off();
        test_tick_period_extremes();
        test_random_traffic(300, 36, 16'($urandom_range(65534, 2)));
        test_random_traffic(300, 88, 16'd1);
        test_random_traffic(300, 0, 16'hFFFF);
        settle();
        if (miscompares == 0) begin
            $display("** edf_periodic_task_scheduler_top: PASSED **");
        end else begin
            $display("** edf_periodic_task_scheduler_top: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/edfs_pkg.sv
rtl/edfs_cell.sv
rtl/edf_periodic_task_scheduler_top.sv
rtl/edfs_checker.sv
dv/edf_periodic_task_scheduler_top_tb.sv
